>>> design/chp2_pkg.sv
package chp2_pkg;

  localparam int unsigned TW = 17;
  localparam int unsigned DW = 32;
  localparam int unsigned PW = 49;
  localparam int unsigned AW = 66;

  localparam logic [TW-1:0] ONE_Q16   = 17'd65536;
  localparam logic [17:0]   THREE_Q16 = 18'd196608;
  localparam logic [PW:0]   WGT_RND   = 50'd131072;
  localparam logic signed [AW-1:0] ACC_RND = 66'sd536870912;

  localparam logic signed [DW-1:0] OUT_MAX = 32'sh7fff_ffff;
  localparam logic signed [DW-1:0] OUT_MIN = 32'sh8000_0000;

  // three stages make the weights, three more the weighted sum
  localparam int unsigned WGT_LAT = 3;
  localparam int unsigned MAC_LAT = 3;

  typedef struct packed {
    logic signed [DW-1:0] w_p0;
    logic signed [DW-1:0] w_m0;
    logic signed [DW-1:0] w_p1;
    logic signed [DW-1:0] w_m1;
  } chp2_weights_t;

  typedef struct packed {
    logic signed [DW-1:0] p0;
    logic signed [DW-1:0] m0;
    logic signed [DW-1:0] p1;
    logic signed [DW-1:0] m1;
  } chp2_ops_t;

endpackage

>>> design/cubic_hermite_point_2d.sv
// Cubic Hermite curve point, 2D, Q16.16. Pulse start with t_param and the two
// endpoints and tangents; when the item leaves the pipeline, valid_o is high for one cycle
// with the point on out_x_o/out_y_o and saturated_o set if either axis clipped.
// The six-stage pipeline (three for the basis weights, three for the per-axis
// multiply, sum and round) takes a new item every cycle and busy stays low.
// Results cannot be held off, so they must be captured in the valid_o cycle.
// t_param above 65536 is taken as 1.0.
module cubic_hermite_point_2d import chp2_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  logic [TW-1:0]        t_param_i,
  input  logic signed [DW-1:0] start_x_i,
  input  logic signed [DW-1:0] start_y_i,
  input  logic signed [DW-1:0] end_x_i,
  input  logic signed [DW-1:0] end_y_i,
  input  logic signed [DW-1:0] start_tan_x_i,
  input  logic signed [DW-1:0] start_tan_y_i,
  input  logic signed [DW-1:0] end_tan_x_i,
  input  logic signed [DW-1:0] end_tan_y_i,
  output logic                 valid_o,
  output logic signed [DW-1:0] out_x_o,
  output logic signed [DW-1:0] out_y_o,
  output logic                 saturated_o
);

  logic          accept;
  logic          wgt_vld;
  chp2_weights_t weights;
  chp2_ops_t     ops_x_d, ops_y_d;
  chp2_ops_t     ops_x_q [WGT_LAT];
  chp2_ops_t     ops_y_q [WGT_LAT];
  logic [MAC_LAT-1:0] vld_q;
  logic          sat_x, sat_y;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  always_comb begin
    ops_x_d.p0 = start_x_i;
    ops_x_d.m0 = start_tan_x_i;
    ops_x_d.p1 = end_x_i;
    ops_x_d.m1 = end_tan_x_i;
    ops_y_d.p0 = start_y_i;
    ops_y_d.m0 = start_tan_y_i;
    ops_y_d.p1 = end_y_i;
    ops_y_d.m1 = end_tan_y_i;
  end

  chp2_weight u_weight (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (accept),
    .t_param_i (t_param_i),
    .valid_o   (wgt_vld),
    .weights_o (weights)
  );

  // operands wait alongside the weight pipeline
  always_ff @(posedge clk_i) begin
    ops_x_q[0] <= ops_x_d;
    ops_y_q[0] <= ops_y_d;
    for (int i = 1; i < WGT_LAT; i++) begin
      ops_x_q[i] <= ops_x_q[i-1];
      ops_y_q[i] <= ops_y_q[i-1];
    end
  end

  chp2_mac u_mac_x (
    .clk_i     (clk_i),
    .weights_i (weights),
    .ops_i     (ops_x_q[WGT_LAT-1]),
    .value_o   (out_x_o),
    .sat_o     (sat_x)
  );

  chp2_mac u_mac_y (
    .clk_i     (clk_i),
    .weights_i (weights),
    .ops_i     (ops_y_q[WGT_LAT-1]),
    .value_o   (out_y_o),
    .sat_o     (sat_y)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[MAC_LAT-2:0], wgt_vld};
    end
  end

  assign valid_o     = vld_q[MAC_LAT-1];
  assign saturated_o = sat_x || sat_y;

endmodule

>>> design/chp2_weight.sv
module chp2_weight import chp2_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  input  logic [TW-1:0]   t_param_i,
  output logic            valid_o,
  output chp2_weights_t   weights_o
);

  logic [WGT_LAT-1:0] vld_q;

  logic [TW-1:0] t_c;
  logic [TW-1:0] t_d, t_q, s_d, s_q;
  logic [33:0]   tt_d, tt_q, ss_d, ss_q;

  logic [17:0]   a0, a2;
  logic [51:0]   prod0, prod1, prod2, prod3;
  logic [PW-1:0] p0_q, p1_q, p2_q, p3_q;

  logic [PW:0]   r0, r1, r2, r3;
  chp2_weights_t w_d, w_q;

  // stage 1: clamp t, squares and complement
  always_comb begin
    t_c  = (t_param_i > ONE_Q16) ? ONE_Q16 : t_param_i;
    t_d  = t_c;
    s_d  = ONE_Q16 - t_c;
    tt_d = 34'(t_c) * 34'(t_c);
    ss_d = 34'(s_d) * 34'(s_d);
  end

  // stage 2: exact Q.48 basis magnitudes
  always_comb begin
    a0    = {1'b0, ONE_Q16} + {t_q, 1'b0};
    a2    = THREE_Q16 - {t_q, 1'b0};
    prod0 = 52'(a0) * 52'(ss_q);
    prod1 = 52'(t_q) * 52'(ss_q);
    prod2 = 52'(a2) * 52'(tt_q);
    prod3 = 52'(s_q) * 52'(tt_q);
  end

  // stage 3: round to Q.30, halves away from zero
  always_comb begin
    r0 = {1'b0, p0_q} + WGT_RND;
    r1 = {1'b0, p1_q} + WGT_RND;
    r2 = {1'b0, p2_q} + WGT_RND;
    r3 = {1'b0, p3_q} + WGT_RND;
    w_d.w_p0 = r0[PW:18];
    w_d.w_m0 = r1[PW:18];
    w_d.w_p1 = r2[PW:18];
    w_d.w_m1 = -r3[PW:18];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[WGT_LAT-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    t_q  <= t_d;
    s_q  <= s_d;
    tt_q <= tt_d;
    ss_q <= ss_d;
    p0_q <= prod0[PW-1:0];
    p1_q <= prod1[PW-1:0];
    p2_q <= prod2[PW-1:0];
    p3_q <= prod3[PW-1:0];
    w_q  <= w_d;
  end

  assign valid_o   = vld_q[WGT_LAT-1];
  assign weights_o = w_q;

endmodule

>>> design/chp2_mac.sv
module chp2_mac import chp2_pkg::*; (
  input  logic                 clk_i,
  input  chp2_weights_t        weights_i,
  input  chp2_ops_t            ops_i,
  output logic signed [DW-1:0] value_o,
  output logic                 sat_o
);

  logic signed [63:0]    m0_d, m1_d, m2_d, m3_d;
  logic signed [63:0]    m0_q, m1_q, m2_q, m3_q;
  logic signed [AW-1:0]  acc_d, acc_q;
  logic signed [AW-1:0]  x;
  logic [AW-31:0]        q;
  logic                  ovf;
  logic signed [DW-1:0]  val_d, val_q;
  logic                  sat_q;

  always_comb begin
    m0_d = 64'(weights_i.w_p0) * 64'(ops_i.p0);
    m1_d = 64'(weights_i.w_m0) * 64'(ops_i.m0);
    m2_d = 64'(weights_i.w_p1) * 64'(ops_i.p1);
    m3_d = 64'(weights_i.w_m1) * 64'(ops_i.m1);
  end

  assign acc_d = {{2{m0_q[63]}}, m0_q} + {{2{m1_q[63]}}, m1_q}
               + {{2{m2_q[63]}}, m2_q} + {{2{m3_q[63]}}, m3_q};

  // floor((acc + 2^29) / 2^30), then clip to 32 bits
  always_comb begin
    x     = acc_q + ACC_RND;
    q     = x[AW-1:30];
    ovf   = (q[AW-31:31] != '0) && (q[AW-31:31] != '1);
    val_d = ovf ? (q[AW-31] ? OUT_MIN : OUT_MAX) : q[31:0];
  end

  always_ff @(posedge clk_i) begin
    m0_q  <= m0_d;
    m1_q  <= m1_d;
    m2_q  <= m2_d;
    m3_q  <= m3_d;
    acc_q <= acc_d;
    val_q <= val_d;
    sat_q <= ovf;
  end

  assign value_o = val_q;
  assign sat_o   = sat_q;

endmodule

>>> design/chp2_checker.sv
module chp2_checker import chp2_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  input  logic                 busy,
  input  logic [TW-1:0]        t_param_i,
  input  logic signed [DW-1:0] start_x_i,
  input  logic signed [DW-1:0] start_y_i,
  input  logic signed [DW-1:0] end_x_i,
  input  logic signed [DW-1:0] end_y_i,
  input  logic signed [DW-1:0] start_tan_x_i,
  input  logic signed [DW-1:0] start_tan_y_i,
  input  logic signed [DW-1:0] end_tan_x_i,
  input  logic signed [DW-1:0] end_tan_y_i,
  input  logic                 valid_o,
  input  logic signed [DW-1:0] out_x_o,
  input  logic signed [DW-1:0] out_y_o,
  input  logic                 saturated_o
);

  // cycles since reset, saturating once the pipeline has filled
  logic [2:0] cnt_d, cnt_q;
  logic       warm;

  assign cnt_d = (cnt_q == 3'd6) ? cnt_q : cnt_q + 3'd1;
  assign warm  = (cnt_q == 3'd6);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  a_one_per_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    warm |-> (valid_o == $past(start && !busy, 6)))
    else $error("result strobe does not match item accepted six cycles earlier");

  a_sat_extreme: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && saturated_o) |-> (out_x_o == OUT_MAX || out_x_o == OUT_MIN ||
                                  out_y_o == OUT_MAX || out_y_o == OUT_MIN))
    else $error("saturated flag without a clipped coordinate");

  a_t_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (warm && $past(start && !busy && t_param_i == '0, 6)) |->
      (out_x_o == $past(start_x_i, 6) && out_y_o == $past(start_y_i, 6) && !saturated_o))
    else $error("t of zero does not return the start point");

  a_t_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (warm && $past(start && !busy && t_param_i >= ONE_Q16, 6)) |->
      (out_x_o == $past(end_x_i, 6) && out_y_o == $past(end_y_i, 6) && !saturated_o))
    else $error("t of one does not return the end point");

endmodule

bind cubic_hermite_point_2d chp2_checker u_chp2_checker (.*);

>>> bench/tb.sv
module tb;
  import chp2_pkg::*;

  localparam int unsigned QUIET_LIMIT = 2000;
  localparam int unsigned DRAIN_CYCLES = 16;
  localparam longint HALF_LSB = 64'sd536870912;
  localparam logic signed [DW-1:0] COORD_MAX = 32'sh7fff_ffff;
  localparam logic signed [DW-1:0] COORD_MIN = 32'sh8000_0000;

  typedef struct packed {
    logic [TW-1:0]        t_val;
    logic signed [DW-1:0] p0x;
    logic signed [DW-1:0] p0y;
    logic signed [DW-1:0] p1x;
    logic signed [DW-1:0] p1y;
    logic signed [DW-1:0] m0x;
    logic signed [DW-1:0] m0y;
    logic signed [DW-1:0] m1x;
    logic signed [DW-1:0] m1y;
  } curve_item_t;

  typedef struct packed {
    logic signed [DW-1:0] x;
    logic signed [DW-1:0] y;
    logic                 sat;
  } curve_point_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 start;
  logic                 busy;
  logic [TW-1:0]        t_param_i;
  logic signed [DW-1:0] start_x_i, start_y_i, end_x_i, end_y_i;
  logic signed [DW-1:0] start_tan_x_i, start_tan_y_i, end_tan_x_i, end_tan_y_i;
  logic                 valid_o;
  logic signed [DW-1:0] out_x_o, out_y_o;
  logic                 saturated_o;

  curve_point_t pending_points[$];
  int unsigned  mismatch_cnt = 0;
  int unsigned  quiet_cycles = 0;
  int unsigned  idle_pct = 0;

  always #4 clk_i = ~clk_i;

  cubic_hermite_point_2d dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy),
    .t_param_i(t_param_i),
    .start_x_i(start_x_i), .start_y_i(start_y_i),
    .end_x_i(end_x_i), .end_y_i(end_y_i),
    .start_tan_x_i(start_tan_x_i), .start_tan_y_i(start_tan_y_i),
    .end_tan_x_i(end_tan_x_i), .end_tan_y_i(end_tan_y_i),
    .valid_o(valid_o), .out_x_o(out_x_o), .out_y_o(out_y_o),
    .saturated_o(saturated_o)
  );

  // weighted sum of one axis, rounded half up to Q16.16 and clipped
  function automatic logic signed [DW-1:0] blend_axis(
      input longint w0, input longint w1, input longint w2, input longint w3,
      input logic signed [DW-1:0] p0, input logic signed [DW-1:0] m0,
      input logic signed [DW-1:0] p1, input logic signed [DW-1:0] m1,
      output logic clipped);
    longint acc;
    longint q;
    acc = w0 * longint'(p0) + w1 * longint'(m0) + w2 * longint'(p1) + w3 * longint'(m1);
    q = (acc + HALF_LSB) >>> 30;
    clipped = 1'b0;
    if (q > longint'(COORD_MAX)) begin
      clipped = 1'b1;
      q = longint'(COORD_MAX);
    end else if (q < longint'(COORD_MIN)) begin
      clipped = 1'b1;
      q = longint'(COORD_MIN);
    end
    return q[DW-1:0];
  endfunction

  function automatic curve_point_t hermite_point(input curve_item_t c);
    longint unsigned tt;
    longint unsigned ss;
    longint w0, w1, w2, w3;
    logic clip_x, clip_y;
    curve_point_t r;
    tt = c.t_val;
    if (tt > 65536) tt = 65536;
    ss = 65536 - tt;
    // Q.48 weights rounded to Q.30, halves away from zero
    w0 = longint'(((65536 + 2 * tt) * ss * ss + 131072) >> 18);
    w1 = longint'((tt * ss * ss + 131072) >> 18);
    w2 = longint'((tt * tt * (3 * 65536 - 2 * tt) + 131072) >> 18);
    w3 = -longint'((tt * tt * ss + 131072) >> 18);
    r.x = blend_axis(w0, w1, w2, w3, c.p0x, c.m0x, c.p1x, c.m1x, clip_x);
    r.y = blend_axis(w0, w1, w2, w3, c.p0y, c.m0y, c.p1y, c.m1y, clip_y);
    r.sat = clip_x | clip_y;
    return r;
  endfunction

  function automatic curve_item_t make_curve(
      input logic [TW-1:0] t_val,
      input logic signed [DW-1:0] p0x, input logic signed [DW-1:0] p0y,
      input logic signed [DW-1:0] p1x, input logic signed [DW-1:0] p1y,
      input logic signed [DW-1:0] m0x, input logic signed [DW-1:0] m0y,
      input logic signed [DW-1:0] m1x, input logic signed [DW-1:0] m1y);
    curve_item_t c;
    c.t_val = t_val;
    c.p0x = p0x; c.p0y = p0y; c.p1x = p1x; c.p1y = p1y;
    c.m0x = m0x; c.m0y = m0y; c.m1x = m1x; c.m1y = m1y;
    return c;
  endfunction

  function automatic logic signed [DW-1:0] rand_coord();
    logic signed [DW-1:0] r;
    case ($urandom_range(9))
      0: begin
        case ($urandom_range(3))
          0: r = COORD_MAX;
          1: r = COORD_MIN;
          2: r = '0;
          default: r = '1;
        endcase
      end
      1, 2, 3, 4: r = $urandom;
      default: r = int'($urandom_range(2097152)) - 1048576;
    endcase
    return r;
  endfunction

  function automatic curve_item_t rand_curve();
    logic [TW-1:0] t_val;
    case ($urandom_range(9))
      0: t_val = $urandom_range(1) ? 17'd65536 : 17'd0;
      1: t_val = TW'($urandom_range(131071, 65537));
      default: t_val = TW'($urandom_range(65536));
    endcase
    return make_curve(t_val, rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                      rand_coord(), rand_coord(), rand_coord(), rand_coord());
  endfunction

  task automatic send_curve(input curve_item_t c);
    start         <= 1'b1;
    t_param_i     <= c.t_val;
    start_x_i     <= c.p0x;
    start_y_i     <= c.p0y;
    end_x_i       <= c.p1x;
    end_y_i       <= c.p1y;
    start_tan_x_i <= c.m0x;
    start_tan_y_i <= c.m0y;
    end_tan_x_i   <= c.m1x;
    end_tan_y_i   <= c.m1y;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    // idle gap with junk on the fields, it must be ignored
    while ($urandom_range(99) < idle_pct) begin
      start     <= 1'b0;
      t_param_i <= TW'($urandom);
      start_x_i <= $urandom;
      @(posedge clk_i);
    end
  endtask

  // checks each result and predicts the point of each accepted item
  always @(posedge clk_i) begin
    curve_point_t want;
    if (valid_o) begin
      if (pending_points.size() == 0) begin
        $display("%0t unexpected point x %0d y %0d sat %0b",
                 $time, out_x_o, out_y_o, saturated_o);
        mismatch_cnt++;
      end else begin
        want = pending_points.pop_front();
        if (out_x_o !== want.x) begin
          $display("%0t out_x expected %0d got %0d", $time, want.x, out_x_o);
          mismatch_cnt++;
        end
        if (out_y_o !== want.y) begin
          $display("%0t out_y expected %0d got %0d", $time, want.y, out_y_o);
          mismatch_cnt++;
        end
        if (saturated_o !== want.sat) begin
          $display("%0t saturated expected %0b got %0b", $time, want.sat, saturated_o);
          mismatch_cnt++;
        end
      end
    end
    if (rst_ni && start && !busy) begin
      pending_points.push_back(hermite_point(make_curve(t_param_i,
          start_x_i, start_y_i, end_x_i, end_y_i,
          start_tan_x_i, start_tan_y_i, end_tan_x_i, end_tan_y_i)));
    end
    if (valid_o || (rst_ni && start && !busy)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("%0t watchdog: no progress", $time);
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  task automatic test_parameter_ends();
    logic signed [DW-1:0] a, b, c, d;
    a = 32'sh0001_0000;  // 1.0
    b = -32'sh0002_8000; // -2.5
    c = 32'sh0003_4000;
    d = -32'sh0000_c000;
    send_curve(make_curve(17'd0, a, b, c, d, b, c, d, a));
    send_curve(make_curve(17'd65536, a, b, c, d, b, c, d, a));
    // parameter above one behaves as one
    send_curve(make_curve(17'd65537, a, b, c, d, b, c, d, a));
    send_curve(make_curve(17'd131071, a, b, c, d, b, c, d, a));
    send_curve(make_curve(17'd1, a, b, c, d, b, c, d, a));
    send_curve(make_curve(17'd65535, a, b, c, d, b, c, d, a));
    send_curve(make_curve(17'd32768, a, b, c, d, b, c, d, a));
  endtask

  task automatic test_saturation();
    // tangents pulling the same way push past full scale
    send_curve(make_curve(17'd32768, COORD_MAX, 32'sd5, COORD_MAX, -32'sd5,
                          COORD_MAX, 32'sd7, COORD_MIN, 32'sd9));
    send_curve(make_curve(17'd32768, 32'sd3, COORD_MIN, 32'sd4, COORD_MIN,
                          32'sd1, COORD_MIN, 32'sd2, COORD_MAX));
    send_curve(make_curve(17'd16384, COORD_MAX, COORD_MIN, COORD_MAX, COORD_MIN,
                          COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX));
    // tangent terms cancel, lands exactly on full scale
    send_curve(make_curve(17'd32768, COORD_MAX, COORD_MIN, COORD_MAX, COORD_MIN,
                          COORD_MAX, COORD_MIN, COORD_MAX, COORD_MIN));
    send_curve(make_curve(17'd49152, COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX,
                          COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX));
  endtask

  task automatic test_rounding();
    send_curve(make_curve(17'd0, '0, '0, '0, '0, '0, '0, '0, '0));
    send_curve(make_curve(17'd1, 32'sd0, -32'sd1, 32'sd1, 32'sd0,
                          -32'sd1, 32'sd1, 32'sd1, -32'sd1));
    send_curve(make_curve(17'd3, 32'sd1, -32'sd1, -32'sd1, 32'sd1,
                          32'sd1, -32'sd1, -32'sd1, 32'sd1));
    send_curve(make_curve(17'd21845, 32'sd1, -32'sd3, 32'sd2, 32'sd5,
                          -32'sh8000, 32'sh8000, 32'sh7fff, -32'sh7fff));
    send_curve(make_curve(17'd43690, -32'sd1, 32'sd1, -32'sd2, 32'sd3,
                          32'sh0000_8000, -32'sh0000_8000, 32'sd1, -32'sd1));
  endtask

  task automatic test_random();
    int unsigned phase_pct[4];
    phase_pct[0] = 0;
    phase_pct[1] = 52;
    phase_pct[2] = 0;
    phase_pct[3] = 11;
    for (int p = 0; p < 4; p++) begin
      idle_pct = phase_pct[p];
      repeat (138) send_curve(rand_curve());
    end
  endtask

  initial begin
    rst_ni        = 1'b0;
    start         = 1'b0;
    t_param_i     = '0;
    start_x_i     = '0;
    start_y_i     = '0;
    end_x_i       = '0;
    end_y_i       = '0;
    start_tan_x_i = '0;
    start_tan_y_i = '0;
    end_tan_x_i   = '0;
    end_tan_y_i   = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_parameter_ends();
    test_saturation();
    test_rounding();
    test_random();
    start <= 1'b0;
    while (pending_points.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

>>> sim.f
design/chp2_pkg.sv
design/chp2_weight.sv
design/chp2_mac.sv
design/cubic_hermite_point_2d.sv
design/chp2_checker.sv
bench/tb.sv
